// ===== rtl/bpt_pkg.sv =====
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared types, codes and sizes of the beacon presence table.
// ----------------------------------------------------------------------------
`default_nettype none

package bpt_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_PRESENCE_TIMEOUT = '0;
	localparam logic [31:0] PRESENCE_TIMEOUT_RST = 32'd1000;

	// input item kinds
	typedef enum logic [1:0] {
		KIND_UPDATE = 2'd0,
		KIND_TRACK  = 2'd1,
		KIND_TICK   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// presence of a table entry
	typedef enum logic [1:0] {
		PRES_MISSING = 2'd0,
		PRES_PRESENT = 2'd1,
		PRES_LOST    = 2'd2
	} pres_t;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_PRESENT = 2'd0,
		STATUS_LOST    = 2'd1,
		STATUS_FULL    = 2'd2
	} status_t;

	// one table entry
	typedef struct packed {
		logic [31:0] key;
		logic [15:0] meas_dist;
		logic [31:0] tstamp;
		pres_t       pres;
		logic        tracked;
	} entry_t;

	// one result item
	typedef struct packed {
		status_t     status;
		logic [15:0] major;
		logic [15:0] minor;
		logic [15:0] meas_dist;
		logic [31:0] tstamp;
		logic        last;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd_en;
		logic inc_idx;
		logic wr_update;
		logic wr_insert;
		logic wr_lost;
		logic push_pend;
		logic emit_present;
		logic emit_full;
		logic flush_pend;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  at_end;
		logic  full;
		logic  key_match;
		logic  expire;
		logic  tracked;
		logic  report_ok;
		logic  pend_valid;
		logic  out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/bpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpt_ctrl
// Sequencer for lookup, insert and aging sweeps over the beacon table.
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_ctrl import bpt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      idle
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_EVAL   = 5'b00100,
		ST_INSERT = 5'b01000,
		ST_FLUSH  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign idle = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				if (sts.kind == KIND_NONE) begin
					state_d = ST_IDLE;
				end else if (sts.at_end) begin
					state_d = (sts.kind == KIND_TICK) ? ST_FLUSH : ST_INSERT;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.kind == KIND_TICK) begin
					// aging check of one entry
					if (sts.expire && sts.report_ok) begin
						if (!sts.pend_valid || sts.out_free) begin
							cmd.wr_lost   = 1'b1;
							cmd.push_pend = 1'b1;
							cmd.inc_idx   = 1'b1;
							state_d       = ST_READ;
						end
					end else begin
						cmd.wr_lost = sts.expire;
						cmd.inc_idx = 1'b1;
						state_d     = ST_READ;
					end
				end else if (sts.key_match) begin
					// found: merge item into entry, report tracked updates
					if (sts.kind == KIND_UPDATE && sts.tracked) begin
						if (sts.out_free) begin
							cmd.wr_update    = 1'b1;
							cmd.emit_present = 1'b1;
							state_d          = ST_IDLE;
						end
					end else begin
						cmd.wr_update = 1'b1;
						state_d       = ST_IDLE;
					end
				end else begin
					cmd.inc_idx = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_INSERT: begin
				if (sts.full) begin
					if (sts.out_free) begin
						cmd.emit_full = 1'b1;
						state_d       = ST_IDLE;
					end
				end else begin
					cmd.wr_insert = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (!sts.pend_valid) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.flush_pend = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/bpt_datapath.sv =====
// ----------------------------------------------------------------------------
// bpt_datapath
// Entry memory, scan counters, age compare and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_datapath import bpt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [31:0] timeout,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] beacon_major,
	input  wire logic [15:0] beacon_minor,
	input  wire logic [15:0] distance,
	input  wire logic [31:0] time_now,
	output res_t             res,
	output logic             res_valid,
	input  wire logic        res_stall
);

	entry_t            mem [TABLE_DEPTH];
	entry_t            rdata_q;
	kind_t             kind_q;
	logic [31:0]       key_q;
	logic [15:0]       dist_q;
	logic [31:0]       time_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  count_q;
	logic [NRES_W-1:0] nres_q;
	res_t              pend_q;
	logic              pend_valid_q;
	res_t              out_q;
	logic              out_valid_q;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	entry_t            mem_wdata;
	entry_t            fresh;
	entry_t            merged;
	logic [31:0]       age;
	logic              out_free;
	logic              out_load;
	res_t              out_next;
	res_t              lost_res;
	res_t              present_res;
	res_t              full_res;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind_t'(kind);
			key_q  <= {beacon_major, beacon_minor};
			dist_q <= distance;
			time_q <= time_now;
		end
	end

	// new entry as left by the item
	always_comb begin
		fresh.key       = key_q;
		fresh.meas_dist = (kind_q == KIND_UPDATE) ? dist_q : 16'd0;
		fresh.tstamp    = (kind_q == KIND_UPDATE) ? time_q : 32'd0;
		fresh.pres      = (kind_q == KIND_UPDATE) ? PRES_PRESENT : PRES_MISSING;
		fresh.tracked   = (kind_q == KIND_TRACK);
	end

	// existing entry merged with the item
	always_comb begin
		merged = rdata_q;
		if (kind_q == KIND_UPDATE) begin
			merged.meas_dist = dist_q;
			merged.tstamp    = time_q;
			merged.pres      = PRES_PRESENT;
		end else begin
			merged.tracked = 1'b1;
		end
	end

	// write port select
	always_comb begin
		mem_we    = cmd.wr_insert | cmd.wr_update | cmd.wr_lost;
		mem_waddr = idx_q[IDX_W-1:0];
		mem_wdata = merged;
		if (cmd.wr_insert) begin
			mem_waddr = count_q[IDX_W-1:0];
			mem_wdata = fresh;
		end else if (cmd.wr_lost) begin
			mem_wdata      = rdata_q;
			mem_wdata.pres = PRES_LOST;
		end
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[idx_q[IDX_W-1:0]];
		end
	end

	// scan index, fill count and result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
			nres_q  <= '0;
		end else begin
			if (cmd.load) begin
				idx_q  <= '0;
				nres_q <= '0;
			end else begin
				if (cmd.inc_idx) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (cmd.push_pend) begin
					nres_q <= nres_q + NRES_W'(1);
				end
			end
			if (cmd.wr_insert) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// candidate results
	assign age = time_q - rdata_q.tstamp;

	always_comb begin
		lost_res.status    = STATUS_LOST;
		lost_res.major     = rdata_q.key[31:16];
		lost_res.minor     = rdata_q.key[15:0];
		lost_res.meas_dist = rdata_q.meas_dist;
		lost_res.tstamp    = rdata_q.tstamp;
		lost_res.last      = 1'b0;

		present_res.status    = STATUS_PRESENT;
		present_res.major     = key_q[31:16];
		present_res.minor     = key_q[15:0];
		present_res.meas_dist = dist_q;
		present_res.tstamp    = time_q;
		present_res.last      = 1'b1;

		full_res.status    = STATUS_FULL;
		full_res.major     = key_q[31:16];
		full_res.minor     = key_q[15:0];
		full_res.meas_dist = (kind_q == KIND_UPDATE) ? dist_q : 16'd0;
		full_res.tstamp    = (kind_q == KIND_UPDATE) ? time_q : 32'd0;
		full_res.last      = 1'b1;
	end

	// pending lost report, held until the sweep knows which one is final
	always_ff @(posedge clk) begin
		if (cmd.push_pend) begin
			pend_q <= lost_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.push_pend) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.flush_pend) begin
			pend_valid_q <= 1'b0;
		end
	end

	// output register
	assign out_free = !out_valid_q || !res_stall;
	assign out_load = cmd.emit_present | cmd.emit_full | cmd.flush_pend |
		(cmd.push_pend & pend_valid_q);

	always_comb begin
		out_next      = pend_q;
		out_next.last = cmd.flush_pend;
		if (cmd.emit_present) begin
			out_next = present_res;
		end else if (cmd.emit_full) begin
			out_next = full_res;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res       = out_q;
	assign res_valid = out_valid_q;

	// status to controller
	always_comb begin
		sts.kind       = kind_q;
		sts.at_end     = (idx_q == count_q);
		sts.full       = (count_q == CNT_W'(TABLE_DEPTH));
		sts.key_match  = (rdata_q.key == key_q);
		sts.expire     = (rdata_q.pres == PRES_PRESENT) && (age > timeout);
		sts.tracked    = rdata_q.tracked;
		sts.report_ok  = rdata_q.tracked && (nres_q < NRES_W'(MAX_RESULTS));
		sts.pend_valid = pend_valid_q;
		sts.out_free   = out_free;
	end

endmodule

`default_nettype wire

// ===== rtl/beacon_presence_table.sv =====
// ----------------------------------------------------------------------------
// beacon_presence_table
// Associative beacon table with update, tracking and timeout aging.
//
//   channel  direction  handshake             payload
//   item     in         in_valid / in_stall   kind, beacon_major, beacon_minor,
//                                             distance, time_now
//   result   out        out_valid / out_stall status, out_major, out_minor,
//                                             out_distance, out_time, last
//   config   in         apb (psel, penable)   presence_timeout at address 0
//
// An item is accepted only when the sequencer is idle and visits the stored
// entries one after another, each read and then evaluated; the sequential
// scan through the entry memory sets how long it keeps the input closed.
// A tick visits every stored entry.
// Reset empties the table and loads presence_timeout with 1000.
// A stalled result holds the sequencer only when a further result is due.
// ----------------------------------------------------------------------------
`default_nettype none

module beacon_presence_table import bpt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// item input
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         kind,
	input  wire logic [15:0]        beacon_major,
	input  wire logic [15:0]        beacon_minor,
	input  wire logic [15:0]        distance,
	input  wire logic [31:0]        time_now,
	// result output
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic [15:0]             out_major,
	output logic [15:0]             out_minor,
	output logic [15:0]             out_distance,
	output logic [31:0]             out_time,
	output logic                    last,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	logic [31:0] timeout_q;
	logic        cfg_sel;
	cmd_t        cmd;
	sts_t        sts;
	res_t        res;
	logic        idle;

	// configuration register
	assign pready  = 1'b1;
	assign cfg_sel = (paddr[PADDR_W-1:2] == REG_PRESENCE_TIMEOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= PRESENCE_TIMEOUT_RST;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			timeout_q <= pwdata;
		end
	end

	assign prdata = cfg_sel ? timeout_q : '0;

	// sequencer
	bpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (idle)
	);

	// table and result path
	bpt_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.timeout      (timeout_q),
		.kind         (kind),
		.beacon_major (beacon_major),
		.beacon_minor (beacon_minor),
		.distance     (distance),
		.time_now     (time_now),
		.res          (res),
		.res_valid    (out_valid),
		.res_stall    (out_stall)
	);

	assign in_stall     = !idle;
	assign status       = res.status;
	assign out_major    = res.major;
	assign out_minor    = res.minor;
	assign out_distance = res.meas_dist;
	assign out_time     = res.tstamp;
	assign last         = res.last;

endmodule

`default_nettype wire

// ===== rtl/bpt_checker.sv =====
// ----------------------------------------------------------------------------
// bpt_checker
// Port-level checks of the beacon presence table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpt_checker import bpt_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  status,
	input wire logic [15:0] out_major,
	input wire logic [15:0] out_minor,
	input wire logic [15:0] out_distance,
	input wire logic [31:0] out_time,
	input wire logic        last
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(out_major) && $stable(out_minor) && $stable(out_distance) &&
		$stable(out_time) && $stable(last))
		else $error("stalled result changed");

	// an accepted item closes the input in the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while previous still in work");

	// a dropped insert is always the only result of its item
	a_full_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_FULL) |-> last)
		else $error("table full result not marked last");

	// a present report is always the only result of its item
	a_present_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_PRESENT) |-> last)
		else $error("present result not marked last");

	// no unused status code leaves the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == STATUS_PRESENT) || (status == STATUS_LOST) ||
		(status == STATUS_FULL)))
		else $error("unused status code on result");

endmodule

bind beacon_presence_table bpt_checker u_bpt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.out_major    (out_major),
	.out_minor    (out_minor),
	.out_distance (out_distance),
	.out_time     (out_time),
	.last         (last)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the beacon presence table against a cycle-free table model: items
// are sent under random idling and stalls, every result is compared field
// by field, and the presence timeout is rewritten between phases.
// ----------------------------------------------------------------------------

module testbench;
	import bpt_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_TIMEOUT = {REG_PRESENCE_TIMEOUT, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_SPARE   = ADDR_TIMEOUT + PADDR_W'(4);
	localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
	localparam int QUIET_LIMIT  = 4000;
	localparam int POOL_SIZE    = 20;

	// one expected result item
	typedef struct {
		status_t     status;
		logic [15:0] major;
		logic [15:0] minor;
		logic [15:0] meas_dist;
		logic [31:0] stamp;
		logic        last;
	} beacon_report_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         kind = '0;
	logic [15:0]        beacon_major = '0;
	logic [15:0]        beacon_minor = '0;
	logic [15:0]        distance = '0;
	logic [31:0]        time_now = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [15:0]        out_major;
	logic [15:0]        out_minor;
	logic [15:0]        out_distance;
	logic [31:0]        out_time;
	logic               last;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// table model
	int          tbl_count = 0;
	logic [31:0] tbl_key [TABLE_DEPTH];
	logic [15:0] tbl_dist [TABLE_DEPTH];
	logic [31:0] tbl_stamp [TABLE_DEPTH];
	pres_t       tbl_pres [TABLE_DEPTH];
	logic        tbl_tracked [TABLE_DEPTH];
	logic [31:0] timeout_reg = PRESENCE_TIMEOUT_RST;

	beacon_report_t pending_reports[$];
	logic [31:0]    beacon_pool [POOL_SIZE];
	logic [31:0]    clock_now = '0;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             hold_left = 0;
	int             quiet_cycles = 0;
	int             fail_count = 0;

	beacon_presence_table dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind),
		.beacon_major(beacon_major), .beacon_minor(beacon_minor),
		.distance(distance), .time_now(time_now),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.out_major(out_major), .out_minor(out_minor),
		.out_distance(out_distance), .out_time(out_time), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected results of one accepted item
	function automatic void predict_table_item(kind_t k, logic [15:0] maj, logic [15:0] mnr,
			logic [15:0] dist_v, logic [31:0] now);
		logic [31:0]    key;
		logic [31:0]    age;
		int             slot;
		int             reported;
		bit             have_held;
		beacon_report_t held;
		key = {maj, mnr};
		slot = -1;
		reported = 0;
		have_held = 1'b0;
		case (k)
			KIND_UPDATE, KIND_TRACK: begin
				for (int i = 0; i < tbl_count; i++)
					if (slot < 0 && tbl_key[i] == key) slot = i;
				// unknown beacon gets a fresh missing entry while room is left
				if (slot < 0 && tbl_count < TABLE_DEPTH) begin
					slot = tbl_count;
					tbl_key[slot] = key;
					tbl_dist[slot] = '0;
					tbl_stamp[slot] = '0;
					tbl_pres[slot] = PRES_MISSING;
					tbl_tracked[slot] = 1'b0;
					tbl_count++;
				end
				if (slot < 0) begin
					// table full, item dropped
					pending_reports.push_back('{STATUS_FULL, maj, mnr,
						(k == KIND_UPDATE) ? dist_v : 16'd0,
						(k == KIND_UPDATE) ? now : 32'd0, 1'b1});
				end else if (k == KIND_TRACK) begin
					tbl_tracked[slot] = 1'b1;
				end else begin
					tbl_dist[slot] = dist_v;
					tbl_stamp[slot] = now;
					tbl_pres[slot] = PRES_PRESENT;
					if (tbl_tracked[slot])
						pending_reports.push_back('{STATUS_PRESENT, maj, mnr, dist_v, now, 1'b1});
				end
			end
			KIND_TICK: begin
				// sweep in index order, the final report carries last
				for (int i = 0; i < tbl_count; i++) begin
					age = now - tbl_stamp[i];
					if (tbl_pres[i] == PRES_PRESENT && age > timeout_reg) begin
						tbl_pres[i] = PRES_LOST;
						if (tbl_tracked[i] && reported < MAX_RESULTS) begin
							if (have_held) pending_reports.push_back(held);
							held = '{STATUS_LOST, tbl_key[i][31:16], tbl_key[i][15:0],
								tbl_dist[i], tbl_stamp[i], 1'b0};
							have_held = 1'b1;
							reported++;
						end
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					pending_reports.push_back(held);
				end
			end
			default: ;
		endcase
	endfunction

	// offer one item, wait for acceptance, then predict
	task automatic send_item(kind_t k, logic [15:0] maj, logic [15:0] mnr,
			logic [15:0] dist_v, logic [31:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		beacon_major <= maj;
		beacon_minor <= mnr;
		distance <= dist_v;
		time_now <= now;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_table_item(k, maj, mnr, dist_v, now);
	endtask

	// apb write: setup cycle then access cycle
	task automatic write_reg(logic [PADDR_W-1:0] addr, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_TIMEOUT) timeout_reg = value;
	endtask

	// stop sending until all results are in and the block has gone quiet
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// extremes of every field, each kind, boundary ages
	task automatic test_table_basics();
		send_item(KIND_UPDATE, 16'h0000, 16'h0000, 16'h1111, 32'd100);
		send_item(KIND_TRACK, 16'h0000, 16'h0000, 16'h0000, 32'd0);
		send_item(KIND_UPDATE, 16'h0000, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(KIND_TRACK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd0);
		send_item(KIND_UPDATE, 16'hFFFF, 16'hFFFF, 16'h0000, 32'd0);
		send_item(KIND_NONE, 16'($urandom()), 16'($urandom()), 16'($urandom()),
			$urandom());
		send_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd1000);
		send_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd1001);
		send_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd5000);
		send_item(KIND_UPDATE, 16'h0000, 16'h0000, 16'h00FF, 32'd6000);
		send_item(KIND_UPDATE, 16'hFFFF, 16'hFFFF, 16'hFF00, 32'd6000);
		send_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd7001);
		// untracked beacon expires silently
		send_item(KIND_UPDATE, 16'h8000, 16'h0001, 16'h5A5A, 32'd7001);
		send_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd9000);
	endtask

	// zero and maximum timeout, and a write to an unused address
	task automatic test_timeout_settings();
		wait_drained();
		write_reg(ADDR_TIMEOUT, 32'd0);
		send_item(KIND_TRACK, 16'h1234, 16'hABCD, 16'h0000, 32'd0);
		send_item(KIND_UPDATE, 16'h1234, 16'hABCD, 16'd7, 32'd50);
		send_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd50);
		send_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd51);
		wait_drained();
		write_reg(ADDR_TIMEOUT, 32'hFFFF_FFFF);
		send_item(KIND_UPDATE, 16'h1234, 16'hABCD, 16'd8, 32'd5);
		send_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd4);
		wait_drained();
		write_reg(ADDR_SPARE, 32'd3);
		send_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd4);
		wait_drained();
		write_reg(ADDR_TIMEOUT, 32'd1000);
		send_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 32'd4);
	endtask

	// random mix over a small key pool, so the table fills and overflows
	task automatic test_random_traffic(int send_pct, int recv_pct, int count,
			logic [31:0] start_time);
		int          pick;
		logic [31:0] key;
		wait_drained();
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		write_reg(ADDR_TIMEOUT, $urandom_range(300, 20));
		clock_now = start_time;
		repeat (count) begin
			pick = $urandom_range(99);
			key = ($urandom_range(99) < 8) ? $urandom() : beacon_pool[$urandom_range(POOL_SIZE - 1)];
			clock_now += $urandom_range(40);
			if (pick < 45)
				send_item(KIND_UPDATE, key[31:16], key[15:0], 16'($urandom()), clock_now);
			else if (pick < 60)
				send_item(KIND_TRACK, key[31:16], key[15:0], 16'($urandom()), $urandom());
			else if (pick < 94)
				send_item(KIND_TICK, key[31:16], key[15:0], 16'($urandom()), clock_now);
			else
				send_item(KIND_NONE, key[31:16], key[15:0], 16'($urandom()), $urandom());
		end
	endtask

	// long receiver hold-off while items keep coming, then a full pause
	task automatic test_backpressure();
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 8; i++)
			send_item(KIND_TRACK, beacon_pool[i][31:16], beacon_pool[i][15:0], 16'd0, 32'd0);
		hold_left = 300;
		repeat (3) begin
			for (int i = 0; i < 8; i++)
				send_item(KIND_UPDATE, beacon_pool[i][31:16], beacon_pool[i][15:0],
					16'($urandom()), clock_now);
			clock_now += 32'h4000_0000;
			send_item(KIND_TICK, 16'h0000, 16'h0000, 16'h0000, clock_now);
		end
		wait_drained();
	endtask

	// receiver stall, with a hold-off counted here
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		beacon_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected result: status %0d major 0x%0h minor 0x%0h",
					status, out_major, out_minor);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("status", want.status, status);
				check_field("out_major", want.major, out_major);
				check_field("out_minor", want.minor, out_minor);
				check_field("out_distance", want.meas_dist, out_distance);
				check_field("out_time", want.stamp, out_time);
				check_field("last", want.last, last);
			end
		end
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		foreach (beacon_pool[i]) beacon_pool[i] = $urandom();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_basics();
		test_timeout_settings();
		test_random_traffic(31, 48, 90, $urandom());
		test_random_traffic(48, 31, 90, $urandom());
		test_random_traffic(0, 0, 90, 32'hFFFF_FC00);
		test_backpressure();
		wait_drained();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
